// ===== sv/cartesian_cylindrical_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef CARTESIAN_CYLINDRICAL_CONVERTER_MACROS_SVH
`define CARTESIAN_CYLINDRICAL_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CCC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define CCC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ccc_pkg.sv =====
// Shared constants, types and the arctangent table for the coordinate converter.
package ccc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int GUARD        = 20;
   localparam int VEC_W        = 64;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ANG_SHIFT    = 60 - FRAC_BITS;

   // direction codes carried on req_func
   localparam logic FUNC_TO_CYL  = 1'b0;
   localparam logic FUNC_TO_CART = 1'b1;

   localparam logic [63:0]        PI_Q60    = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] PI_Q      = $signed(PI_Q60);
   localparam logic signed [63:0] HALF_PI_Q = $signed(PI_Q60 >> 1);
   localparam logic [63:0]        PI_F64    = PI_Q60 >> ANG_SHIFT;
   localparam logic [31:0]        PI_F32    = PI_F64[31:0];
   localparam logic [31:0]        INV_GAIN  = 32'h9B74EDA8;
   localparam logic [32:0]        RADIUS_MAX = 33'd3037000499;

   typedef struct packed {
      logic                    func;
      logic                    origin;
      logic                    err;
      logic                    flip;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic signed [31:0]      third;
   } ccc_vec_type;

   // atan(2^-i) in units of 2^-60 rad, truncated Taylor series
   function automatic logic [63:0] atan_q60(input int unsigned i);
      logic [63:0] sum;
      logic [63:0] term;
      int unsigned p;
      sum = 64'd0;
      if (i == 0) begin
         sum = PI_Q60 >> 2;
      end else begin
         for (int k = 0; k < 31; k++) begin
            p = i * unsigned'(2 * k + 1);
            if (p <= 60) begin
               term = (64'd1 << (60 - p)) / 64'(2 * k + 1);
               if (k[0]) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
      end
      return sum;
   endfunction

endpackage

// ===== sv/ccc_cordic_stage.sv =====
// One registered CORDIC micro-rotation, shared by vectoring and rotation modes.
module ccc_cordic_stage import ccc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  ccc_vec_type       in_vec,
   input  logic [STEP_W-1:0] step,
   input  logic [63:0]       atan_value,
   output logic              out_valid,
   output ccc_vec_type       out_vec
);

   logic signed [VEC_W-1:0] x_c, y_c, z_c, xs, ys, at;
   logic                    plus;
   logic                    valid_ff;
   ccc_vec_type             vec_ff, vec_in;

   assign x_c = in_vec.x;
   assign y_c = in_vec.y;
   assign z_c = in_vec.z;
   assign xs  = x_c >>> step;
   assign ys  = y_c >>> step;
   assign at  = $signed(atan_value);

   // vectoring drives y to zero, rotation drives z to zero
   assign plus = (in_vec.func == FUNC_TO_CART) ? z_c[VEC_W-1] : !y_c[VEC_W-1];

   always_comb begin
      vec_in = in_vec;
      if (plus) begin
         vec_in.x = x_c + ys;
         vec_in.y = y_c - xs;
         vec_in.z = z_c + at;
      end else begin
         vec_in.x = x_c - ys;
         vec_in.y = y_c + xs;
         vec_in.z = z_c - at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// ===== sv/cartesian_cylindrical_converter.sv =====
// Top level: pipelined CORDIC Cartesian <-> cylindrical vector converter.
//
// Usage:
//  - req_ channel carries one 3-vector beat: req_func selects the direction
//    (0: x,y,z -> radius,angle,z; 1: radius,angle,z -> x,y,z), Q16.16 values.
//  - rsp_ channel returns one beat per request, in order, with range_error
//    set (and all values zero) for a cylindrical angle beyond +/-pi.
//  - An accepted request beat passes 29 registers: input register, two
//    setup stages (one holds the 32x32 gain multiply), 24 CORDIC stages,
//    one gain/round stage and the output register.
//  - Throughput is one beat per cycle while rsp_ready does not stall the
//    output; the 24-stage CORDIC chain is the bulk of the pipe, each stage
//    three 64-bit add/subtracts.
//  - A stalled rsp_ready holds the output beat; upstream stages keep filling
//    empty slots, so req_ready drops only when every stage holds a beat.
//  - Synchronous reset clears all valid bits; no beat is in flight after it.
module cartesian_cylindrical_converter import ccc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_in_first,
   input  logic signed [31:0] req_in_second,
   input  logic signed [31:0] req_in_third,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [32:0] rsp_out_first,
   output logic signed [31:0] rsp_out_second,
   output logic signed [31:0] rsp_out_third,
   output logic               rsp_range_error
);

`include "cartesian_cylindrical_converter_macros.svh"

   typedef struct packed {
      logic               func;
      logic               origin;
      logic               err;
      logic [63:0]        hi;
      logic [63:0]        lo;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] third;
   } ccc_post_type;

   // ---------------- stage enables ----------------
   // A stage loads when it is empty or the stage after it loads too, so
   // bubbles collapse and a stall only backs up as far as it must.
   logic                    s0_en, s1_en, s2_en, q1_en, q2_en;
   logic [CORDIC_STEPS-1:0] c_en;

   // ---------------- stage registers ----------------
   logic               s0_valid_ff, s0_func_ff;
   logic signed [31:0] s0_a_ff, s0_b_ff, s0_c_ff;
   logic               s1_valid_ff, s2_valid_ff, q1_valid_ff, rsp_valid_ff;
   ccc_vec_type        s1_vec_ff, s1_vec_in, s2_vec_ff, s2_vec_in;
   ccc_post_type       q1_ff, q1_in;
   logic               out_func_ff;

   logic [CORDIC_STEPS:0] cv_valid;
   ccc_vec_type           cv_vec [CORDIC_STEPS+1];

   logic signed [32:0] rsp_first_in;
   logic signed [31:0] rsp_second_in, rsp_third_in;
   logic               rsp_err_in;

   assign q2_en = !rsp_valid_ff || rsp_ready;
   assign q1_en = !q1_valid_ff || q2_en;
   assign s2_en = !s2_valid_ff || c_en[0];
   assign s1_en = !s1_valid_ff || s2_en;
   assign s0_en = !s0_valid_ff || s1_en;
   assign req_ready = s0_en;

   // ---------------- stage 0: input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_func_ff <= req_func;
         s0_a_ff    <= req_in_first;
         s0_b_ff    <= req_in_second;
         s0_c_ff    <= req_in_third;
      end
   end

   // ---------------- stage 1: quadrant fold, gain multiply ----------------
   logic signed [63:0] a_ext, b_ext, zm_s, zs;
   logic [31:0]        am, rm;
   logic [63:0]        prod;
   logic               reduce;

   always_comb begin
      a_ext  = 64'(s0_a_ff) <<< GUARD;
      b_ext  = 64'(s0_b_ff) <<< GUARD;
      am     = s0_b_ff[31] ? 32'(-s0_b_ff) : 32'(s0_b_ff);
      rm     = s0_a_ff[31] ? 32'(-s0_a_ff) : 32'(s0_a_ff);
      // radius pre-scaled by 1/K so the rotation leaves the true length
      prod   = rm * INV_GAIN;
      zm_s   = $signed(64'(am) << ANG_SHIFT);
      zs     = s0_b_ff[31] ? -zm_s : zm_s;
      reduce = 1'b0;

      s1_vec_in        = '0;
      s1_vec_in.func   = s0_func_ff;
      s1_vec_in.third  = s0_c_ff;
      s1_vec_in.origin = (s0_a_ff == 32'sd0) && (s0_b_ff == 32'sd0);
      if (s0_func_ff == FUNC_TO_CYL) begin
         // left half plane: turn by pi first so vectoring converges
         if (s0_a_ff[31]) begin
            s1_vec_in.x = -a_ext;
            s1_vec_in.y = -b_ext;
            s1_vec_in.z = s0_b_ff[31] ? -PI_Q : PI_Q;
         end else begin
            s1_vec_in.x = a_ext;
            s1_vec_in.y = b_ext;
            s1_vec_in.z = 64'sd0;
         end
      end else begin
         s1_vec_in.err = am > PI_F32;
         s1_vec_in.x   = $signed(prod);
         s1_vec_in.y   = 64'sd0;
         // beyond +/-pi/2: rotate by pi less and negate the start vector
         if (zs > HALF_PI_Q) begin
            s1_vec_in.z = zs - PI_Q;
            reduce      = 1'b1;
         end else if (zs < -HALF_PI_Q) begin
            s1_vec_in.z = zs + PI_Q;
            reduce      = 1'b1;
         end else begin
            s1_vec_in.z = zs;
         end
         s1_vec_in.flip = s0_a_ff[31] ^ reduce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_vec_ff <= s1_vec_in;
      end
   end

   // ---------------- stage 2: rotation start vector ----------------
   logic signed [63:0] x_start;

   always_comb begin
      x_start   = $signed($unsigned(s1_vec_ff.x) >> (32 - GUARD));
      s2_vec_in = s1_vec_ff;
      if (s1_vec_ff.func == FUNC_TO_CART) begin
         s2_vec_in.x = s1_vec_ff.flip ? -x_start : x_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_vec_ff <= s2_vec_in;
      end
   end

   // ---------------- CORDIC chain ----------------
   assign cv_valid[0] = s2_valid_ff;
   assign cv_vec[0]   = s2_vec_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      localparam logic [63:0] AtanK = atan_q60(k);

      if (k == CORDIC_STEPS - 1) begin : g_last
         assign c_en[k] = !cv_valid[k+1] || q1_en;
      end else begin : g_mid
         assign c_en[k] = !cv_valid[k+1] || c_en[k+1];
      end

      ccc_cordic_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .load       (c_en[k]),
         .in_valid   (cv_valid[k]),
         .in_vec     (cv_vec[k]),
         .step       (STEP_W'(k)),
         .atan_value (AtanK),
         .out_valid  (cv_valid[k+1]),
         .out_vec    (cv_vec[k+1])
      );
   end

   // ---------------- post 1: gain products, angle and xy rounding ----------
   ccc_vec_type        fin;
   logic signed [63:0] fx, fy, fz, xr, yr;
   logic [63:0]        xc, mag, q, q_sat;

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   always_comb begin
      fin   = cv_vec[CORDIC_STEPS];
      fx    = fin.x;
      fy    = fin.y;
      fz    = fin.z;
      xc    = fx[63] ? 64'd0 : $unsigned(fx);
      mag   = fz[63] ? $unsigned(-fz) : $unsigned(fz);
      q     = (mag + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
      q_sat = (q > PI_F64) ? PI_F64 : q;
      xr    = (fx + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      yr    = (fy + (64'sd1 <<< (GUARD - 1))) >>> GUARD;

      q1_in        = '0;
      q1_in.func   = fin.func;
      q1_in.origin = fin.origin;
      q1_in.err    = fin.err;
      q1_in.third  = fin.third;
      q1_in.hi     = xc[63:32] * INV_GAIN;
      q1_in.lo     = xc[31:0] * INV_GAIN;
      if (fin.func == FUNC_TO_CART) begin
         q1_in.first  = clamp32(xr);
         q1_in.second = clamp32(yr);
      end else begin
         q1_in.second = fz[63] ? -$signed(q_sat[31:0]) : $signed(q_sat[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (q1_en) begin
         q1_valid_ff <= cv_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (q1_en) begin
         q1_ff <= q1_in;
      end
   end

   // ---------------- post 2: radius, output select ----------------
   logic [63:0] rad;

   always_comb begin
      rad = (q1_ff.hi + (q1_ff.lo >> 32) + (64'd1 << (GUARD - 1))) >> GUARD;
      rsp_first_in  = 33'sd0;
      rsp_second_in = 32'sd0;
      rsp_third_in  = 32'sd0;
      rsp_err_in    = 1'b0;
      if (q1_ff.err) begin
         rsp_err_in = 1'b1;
      end else if (q1_ff.func == FUNC_TO_CART) begin
         rsp_first_in  = 33'(q1_ff.first);
         rsp_second_in = q1_ff.second;
         rsp_third_in  = q1_ff.third;
      end else begin
         rsp_third_in = q1_ff.third;
         if (!q1_ff.origin) begin
            rsp_first_in  = (rad > 64'(RADIUS_MAX)) ? $signed(RADIUS_MAX)
                                                    : $signed(rad[32:0]);
            rsp_second_in = q1_ff.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q2_en) begin
         rsp_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q2_en) begin
         rsp_out_first   <= rsp_first_in;
         rsp_out_second  <= rsp_second_in;
         rsp_out_third   <= rsp_third_in;
         rsp_range_error <= rsp_err_in;
         out_func_ff     <= q1_ff.func;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- assertions ----------------
   `CCC_ASSERT_IMP(a_err_zero, rsp_valid && rsp_range_error,
      (rsp_out_first == 33'sd0) && (rsp_out_second == 32'sd0) && (rsp_out_third == 32'sd0),
      "range error beat carries nonzero values")
   `CCC_ASSERT_IMP(a_polar_bounds, rsp_valid && (out_func_ff == FUNC_TO_CYL),
      !rsp_range_error && !rsp_out_first[32] && ($unsigned(rsp_out_first) <= RADIUS_MAX)
         && (rsp_out_second <= $signed(PI_F32)) && (rsp_out_second >= -$signed(PI_F32)),
      "polar result out of range")
   `CCC_ASSERT_IMP(a_full_when_blocked, !req_ready,
      s0_valid_ff && s1_valid_ff && s2_valid_ff && (&cv_valid) && q1_valid_ff && rsp_valid_ff,
      "input blocked while a pipeline slot is empty")
   `CCC_ASSERT_NXT(a_setup_hold, s1_valid_ff && !s2_en,
      s1_valid_ff && $stable(s1_vec_ff),
      "stalled setup stage lost or changed its beat")

endmodule
